>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL. They compile away in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

>>> hw/rtl/secc_pkg.sv
`default_nettype none

package secc_pkg;

   localparam int MAX_BYTES_DEFAULT = 2048;
   localparam int HDR_BYTES         = 20;
   localparam int COUNT_W           = 64;
   localparam int ATTR_TYPE_W       = 16;
   localparam int CODE_W            = 10;
   localparam int CSR_INDEX_W       = 1;
   localparam int CSR_DATA_W        = 16;
   localparam int ATTR_LEN_MAX      = 65535;
   localparam int CODE_SCALE        = 100;

   localparam logic [ATTR_TYPE_W-1:0] ATTR_TYPE_RESET  = 16'h0009;
   localparam logic [CODE_W-1:0]      MATCH_CODE_RESET = 10'd401;

   localparam logic [CSR_INDEX_W-1:0] CSR_MATCH_ATTR_TYPE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MATCH_CODE      = 1'b1;

endpackage

`default_nettype wire

>>> hw/rtl/secc_req_if.sv
`default_nettype none

interface secc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink   (input valid, input data_byte, input last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/secc_rsp_if.sv
`default_nettype none

interface secc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        is_match;
   logic [secc_pkg::COUNT_W-1:0] match_count;
   logic [secc_pkg::COUNT_W-1:0] packet_count;
   logic [secc_pkg::COUNT_W-1:0] byte_count;

   modport source (output valid, output is_match, output match_count,
                   output packet_count, output byte_count, input ready);
   modport sink   (input valid, input is_match, input match_count,
                   input packet_count, input byte_count, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/stun_error_code_classifier.sv
`default_nettype none
`include "assert_macros.svh"

// Parses a received STUN datagram presented one byte per transaction on req_chan, with
// last set on the final byte. The 20-byte header is skipped and the attributes are
// walked until the first one of type match_attr_type with a length of at least four;
// its error code (class times 100 plus number) is compared with match_code. A byte can
// be accepted on every clock while req_chan.ready is high. In the cycle after
// the final byte is accepted a single transaction appears on rsp_chan with the match
// flag and the running datagram, byte and match counts, which wrap at 2^64. Bytes
// past MAX_BYTES are dropped. The result sits in one output register; req_chan.ready
// drops only while that result is waiting and rsp_chan.ready is low. Configuration
// writes on the csr_ port take effect at the next clock and must be made while idle.
module stun_error_code_classifier #(
   parameter int MAX_BYTES = secc_pkg::MAX_BYTES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   secc_req_if.sink                               req_chan,
   secc_rsp_if.source                             rsp_chan,
   input  wire logic                              csr_we,
   input  wire logic [secc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [secc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int OFS_W  = $clog2(MAX_BYTES + 1);
   localparam int ATTR_W = $clog2(MAX_BYTES + secc_pkg::ATTR_LEN_MAX + 8);
   localparam int CW     = secc_pkg::CODE_W;
   localparam int NW     = secc_pkg::COUNT_W;

   logic [secc_pkg::ATTR_TYPE_W-1:0] match_attr_type_ff, match_attr_type_in;
   logic [CW-1:0]                    match_code_ff, match_code_in;

   logic [OFS_W-1:0]  byte_offset_ff, byte_offset_in;
   logic [ATTR_W-1:0] next_attr_offset_ff, next_attr_offset_in;
   logic [23:0]       attr_header_ff, attr_header_in;
   logic              found_ff, found_in;
   logic [2:0]        cand_class_ff, cand_class_in;
   logic [7:0]        cand_number_ff, cand_number_in;
   logic [ATTR_W-1:0] cand_end_ff, cand_end_in;
   logic [NW-1:0]     match_total_ff, match_total_in;
   logic [NW-1:0]     packet_total_ff, packet_total_in;
   logic [NW-1:0]     byte_total_ff, byte_total_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              is_match_ff, is_match_in;

   logic              req_accept;
   logic [ATTR_W-1:0] pos;
   logic [ATTR_W-1:0] rel;
   logic [15:0]       attr_type;
   logic [15:0]       attr_len;
   logic [16:0]       len_rounded;
   logic [OFS_W-1:0]  kept;
   logic [CW-1:0]     code;
   logic              hit;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.is_match     = is_match_ff;
   assign rsp_chan.match_count  = match_total_ff;
   assign rsp_chan.packet_count = packet_total_ff;
   assign rsp_chan.byte_count   = byte_total_ff;

   always_comb begin
      match_attr_type_in = match_attr_type_ff;
      match_code_in      = match_code_ff;
      if (csr_we) begin
         case (csr_index)
            secc_pkg::CSR_MATCH_ATTR_TYPE: match_attr_type_in = csr_wdata;
            secc_pkg::CSR_MATCH_CODE:      match_code_in = csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      byte_offset_in      = byte_offset_ff;
      next_attr_offset_in = next_attr_offset_ff;
      attr_header_in      = attr_header_ff;
      found_in            = found_ff;
      cand_class_in       = cand_class_ff;
      cand_number_in      = cand_number_ff;
      cand_end_in         = cand_end_ff;
      match_total_in      = match_total_ff;
      packet_total_in     = packet_total_ff;
      byte_total_in       = byte_total_ff;
      is_match_in         = is_match_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_chan.ready;

      pos         = ATTR_W'(byte_offset_ff);
      rel         = pos - next_attr_offset_ff;
      attr_type   = attr_header_ff[23:8];
      attr_len    = {attr_header_ff[7:0], req_chan.data_byte};
      len_rounded = ({1'b0, attr_len} + 17'd3) & ~17'd3;

      if (req_accept && (byte_offset_ff < OFS_W'(MAX_BYTES))) begin
         byte_offset_in = byte_offset_ff + OFS_W'(1);
         if (pos >= next_attr_offset_ff) begin
            if (found_ff) begin
               if (rel == ATTR_W'(6)) begin
                  cand_class_in = req_chan.data_byte[2:0];
               end else if (rel == ATTR_W'(7)) begin
                  cand_number_in = req_chan.data_byte;
               end
            end else if (rel < ATTR_W'(3)) begin
               attr_header_in = {attr_header_ff[15:0], req_chan.data_byte};
            end else if (rel == ATTR_W'(3)) begin
               attr_header_in = '0;
               if ((attr_type == match_attr_type_ff) && (attr_len >= 16'd4)) begin
                  found_in    = 1'b1;
                  cand_end_in = next_attr_offset_ff + ATTR_W'(4) + ATTR_W'(attr_len);
               end else begin
                  next_attr_offset_in = next_attr_offset_ff + ATTR_W'(4)
                                        + ATTR_W'(len_rounded);
               end
            end
         end
      end

      kept = byte_offset_in;
      code = CW'(cand_class_in) * CW'(secc_pkg::CODE_SCALE) + CW'(cand_number_in);
      hit  = found_in && (kept >= OFS_W'(secc_pkg::HDR_BYTES))
             && (cand_end_in <= ATTR_W'(kept)) && (code == match_code_ff);

      if (req_accept && req_chan.last) begin
         rsp_valid_in        = 1'b1;
         is_match_in         = hit;
         packet_total_in     = packet_total_ff + NW'(1);
         byte_total_in       = byte_total_ff + NW'(kept);
         match_total_in      = hit ? match_total_ff + NW'(1) : match_total_ff;
         byte_offset_in      = '0;
         next_attr_offset_in = ATTR_W'(secc_pkg::HDR_BYTES);
         attr_header_in      = '0;
         found_in            = 1'b0;
         cand_class_in       = '0;
         cand_number_in      = '0;
         cand_end_in         = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_attr_type_ff  <= secc_pkg::ATTR_TYPE_RESET;
         match_code_ff       <= secc_pkg::MATCH_CODE_RESET;
         byte_offset_ff      <= '0;
         next_attr_offset_ff <= ATTR_W'(secc_pkg::HDR_BYTES);
         attr_header_ff      <= '0;
         found_ff            <= 1'b0;
         cand_class_ff       <= '0;
         cand_number_ff      <= '0;
         cand_end_ff         <= '0;
         match_total_ff      <= '0;
         packet_total_ff     <= '0;
         byte_total_ff       <= '0;
         rsp_valid_ff        <= 1'b0;
         is_match_ff         <= 1'b0;
      end else begin
         match_attr_type_ff  <= match_attr_type_in;
         match_code_ff       <= match_code_in;
         byte_offset_ff      <= byte_offset_in;
         next_attr_offset_ff <= next_attr_offset_in;
         attr_header_ff      <= attr_header_in;
         found_ff            <= found_in;
         cand_class_ff       <= cand_class_in;
         cand_number_ff      <= cand_number_in;
         cand_end_ff         <= cand_end_in;
         match_total_ff      <= match_total_in;
         packet_total_ff     <= packet_total_in;
         byte_total_ff       <= byte_total_in;
         rsp_valid_ff        <= rsp_valid_in;
         is_match_ff         <= is_match_in;
      end
   end

   `ASSERT_PROP(a_offset_capped, clock, reset, byte_offset_ff <= OFS_W'(MAX_BYTES), "byte offset exceeds maximum datagram size")
   `ASSERT_PROP(a_cand_end_span, clock, reset, !found_ff || ((ATTR_W+1)'(cand_end_ff) >= (ATTR_W+1)'(next_attr_offset_ff) + (ATTR_W+1)'(8)), "candidate end too close to its attribute start")
   `ASSERT_NEXT(a_last_gives_rsp, clock, reset, req_accept && req_chan.last, rsp_valid_ff, "final byte did not produce a result")
   `ASSERT_NEXT(a_counts_held, clock, reset, rsp_valid_ff && !rsp_chan.ready, $stable(packet_total_ff) && $stable(match_total_ff) && $stable(byte_total_ff), "counts changed under a pending result")

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_BYTES  = secc_pkg::MAX_BYTES_DEFAULT;
   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_OFF    = 400;

   typedef struct packed {
      logic        hit;
      logic [63:0] match_n;
      logic [63:0] datagrams;
      logic [63:0] octets;
   } verdict_type;

   typedef struct packed {
      logic known;
      logic val;
   } plan_hit_type;

   typedef enum logic { ROW_PKT, ROW_CSR } row_kind_type;

   typedef struct packed {
      row_kind_type                     kind;
      logic [secc_pkg::CSR_INDEX_W-1:0] csr_idx;
      logic [15:0]                      csr_val;
      logic [1:0]                       fill_n;
      logic [15:0]                      fill_type;
      logic [15:0]                      fill_len;
      logic                             has_cand;
      logic [15:0]                      cand_type;
      logic [15:0]                      cand_len;
      logic [7:0]                       cls;
      logic [7:0]                       num;
      logic [11:0]                      extra;
      logic [11:0]                      cut;
      logic                             known;
      logic                             hit;
   } plan_type;

   localparam logic [secc_pkg::CSR_INDEX_W-1:0] CT = secc_pkg::CSR_MATCH_ATTR_TYPE;
   localparam logic [secc_pkg::CSR_INDEX_W-1:0] CC = secc_pkg::CSR_MATCH_CODE;

   plan_type plan [29] = '{
      '{ROW_PKT, CT, 16'h0, 2'd0, 16'h0, 16'd0, 1'b0, 16'h0, 16'd0, 8'h00, 8'h00,
        12'd0, 12'd1, 1'b1, 1'b0},
      '{ROW_PKT, CT, 16'h0, 2'd0, 16'h0, 16'd0, 1'b0, 16'h0, 16'd0, 8'h00, 8'h00,
        12'd0, 12'd19, 1'b1, 1'b0},
      '{ROW_PKT, CT, 16'h0, 2'd0, 16'h0, 16'd0, 1'b0, 16'h0, 16'd0, 8'h00, 8'h00,
        12'd0, 12'd0, 1'b1, 1'b0},
      '{ROW_PKT, CT, 16'h0, 2'd0, 16'h0, 16'd0, 1'b1, 16'h0009, 16'd4, 8'h04, 8'h01,
        12'd0, 12'd0, 1'b1, 1'b1},
      '{ROW_PKT, CT, 16'h0, 2'd0, 16'h0, 16'd0, 1'b1, 16'h0009, 16'd4, 8'hFC, 8'h01,
        12'd0, 12'd0, 1'b1, 1'b1},
      '{ROW_PKT, CT, 16'h0, 2'd0, 16'h0, 16'd0, 1'b1, 16'h0009, 16'd4, 8'h04, 8'h02,
        12'd0, 12'd0, 1'b1, 1'b0},
      '{ROW_PKT, CT, 16'h0, 2'd2, 16'h8022, 16'd5, 1'b1, 16'h0009, 16'd4, 8'h04, 8'h01,
        12'd0, 12'd0, 1'b0, 1'b0},
      '{ROW_PKT, CT, 16'h0, 2'd1, 16'h0009, 16'd3, 1'b1, 16'h0009, 16'd4, 8'h04, 8'h01,
        12'd0, 12'd0, 1'b0, 1'b0},
      '{ROW_PKT, CT, 16'h0, 2'd1, 16'hFFFF, 16'd0, 1'b1, 16'h0009, 16'd4, 8'h04, 8'h01,
        12'd0, 12'd0, 1'b0, 1'b0},
      '{ROW_PKT, CT, 16'h0, 2'd0, 16'h0, 16'd0, 1'b1, 16'h0009, 16'd8, 8'h04, 8'h01,
        12'd0, 12'd30, 1'b1, 1'b0},
      '{ROW_PKT, CT, 16'h0, 2'd0, 16'h0, 16'd0, 1'b1, 16'h0009, 16'd8, 8'h04, 8'h01,
        12'd0, 12'd0, 1'b1, 1'b1},
      '{ROW_PKT, CT, 16'h0, 2'd0, 16'h0, 16'd0, 1'b1, 16'h0009, 16'd4, 8'h07, 8'hFF,
        12'd0, 12'd0, 1'b1, 1'b0},
      '{ROW_PKT, CT, 16'h0, 2'd0, 16'h0, 16'd0, 1'b1, 16'h0009, 16'd4, 8'h04, 8'h01,
        12'd37, 12'd0, 1'b0, 1'b0},
      '{ROW_PKT, CT, 16'h0, 2'd0, 16'h0, 16'd0, 1'b1, 16'h0009, 16'd4, 8'h04, 8'h01,
        12'd2100, 12'd0, 1'b1, 1'b1},
      '{ROW_PKT, CT, 16'h0, 2'd1, 16'h8022, 16'd2016, 1'b1, 16'h0009, 16'd4, 8'h04, 8'h01,
        12'd40, 12'd0, 1'b1, 1'b1},
      '{ROW_PKT, CT, 16'h0, 2'd1, 16'h8022, 16'd2024, 1'b1, 16'h0009, 16'd4, 8'h04, 8'h01,
        12'd30, 12'd0, 1'b1, 1'b0},
      '{ROW_CSR, CC, 16'd955, 2'd0, 16'h0, 16'd0, 1'b0, 16'h0, 16'd0, 8'h00, 8'h00,
        12'd0, 12'd0, 1'b0, 1'b0},
      '{ROW_PKT, CT, 16'h0, 2'd0, 16'h0, 16'd0, 1'b1, 16'h0009, 16'd4, 8'h07, 8'hFF,
        12'd0, 12'd0, 1'b1, 1'b1},
      '{ROW_CSR, CC, 16'd1023, 2'd0, 16'h0, 16'd0, 1'b0, 16'h0, 16'd0, 8'h00, 8'h00,
        12'd0, 12'd0, 1'b0, 1'b0},
      '{ROW_PKT, CT, 16'h0, 2'd0, 16'h0, 16'd0, 1'b1, 16'h0009, 16'd4, 8'h07, 8'hFF,
        12'd0, 12'd0, 1'b1, 1'b0},
      '{ROW_CSR, CC, 16'd0, 2'd0, 16'h0, 16'd0, 1'b0, 16'h0, 16'd0, 8'h00, 8'h00,
        12'd0, 12'd0, 1'b0, 1'b0},
      '{ROW_PKT, CT, 16'h0, 2'd0, 16'h0, 16'd0, 1'b1, 16'h0009, 16'd4, 8'hF8, 8'h00,
        12'd0, 12'd0, 1'b1, 1'b1},
      '{ROW_CSR, CT, 16'hFFFF, 2'd0, 16'h0, 16'd0, 1'b0, 16'h0, 16'd0, 8'h00, 8'h00,
        12'd0, 12'd0, 1'b0, 1'b0},
      '{ROW_PKT, CT, 16'h0, 2'd0, 16'h0, 16'd0, 1'b1, 16'hFFFF, 16'd4, 8'hF8, 8'h00,
        12'd0, 12'd0, 1'b1, 1'b1},
      '{ROW_PKT, CT, 16'h0, 2'd0, 16'h0, 16'd0, 1'b1, 16'h0009, 16'd4, 8'hF8, 8'h00,
        12'd0, 12'd0, 1'b1, 1'b0},
      '{ROW_CSR, CT, 16'h0000, 2'd0, 16'h0, 16'd0, 1'b0, 16'h0, 16'd0, 8'h00, 8'h00,
        12'd0, 12'd0, 1'b0, 1'b0},
      '{ROW_PKT, CT, 16'h0, 2'd1, 16'h8022, 16'd1, 1'b1, 16'h0000, 16'd4, 8'h00, 8'h00,
        12'd0, 12'd0, 1'b0, 1'b0},
      '{ROW_CSR, CT, 16'h0009, 2'd0, 16'h0, 16'd0, 1'b0, 16'h0, 16'd0, 8'h00, 8'h00,
        12'd0, 12'd0, 1'b0, 1'b0},
      '{ROW_CSR, CC, 16'd401, 2'd0, 16'h0, 16'd0, 1'b0, 16'h0, 16'd0, 8'h00, 8'h00,
        12'd0, 12'd0, 1'b0, 1'b0}
   };

   logic clock;
   logic reset;
   logic csr_we;
   logic [secc_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [secc_pkg::CSR_DATA_W-1:0]  csr_wdata;

   secc_req_if req_if ();
   secc_rsp_if rsp_if ();

   stun_error_code_classifier uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   logic [secc_pkg::ATTR_TYPE_W-1:0] pr_attr_type;
   logic [secc_pkg::CODE_W-1:0]      pr_code;
   logic [11:0]            dg_pos;
   logic [16:0]            walk_at;
   logic [23:0]            hdr_bytes;
   logic                   cand_seen;
   logic [2:0]             cand_cls;
   logic [7:0]             cand_num;
   logic [16:0]            cand_stop;
   logic [63:0]            tot_match;
   logic [63:0]            tot_pkt;
   logic [63:0]            tot_bytes;

   verdict_type  verdict_q [$];
   plan_hit_type plan_hit_q [$];
   logic [7:0]   dg_bytes [$];
   int           errors = 0;
   int           rsp_seen = 0;
   int           stall_cycles = 0;
   bit           no_idle = 1'b0;
   bit           held_off = 1'b0;

   task restart_walk;
      dg_pos    = '0;
      walk_at   = 17'(secc_pkg::HDR_BYTES);
      hdr_bytes = '0;
      cand_seen = 1'b0;
      cand_cls  = '0;
      cand_num  = '0;
      cand_stop = '0;
   endtask

   task classify_byte(input logic [7:0] b, input logic fin);
      logic [16:0]  rel;
      logic [15:0]  atype;
      logic [16:0]  alen;
      int           kept;
      int           code;
      verdict_type  v;
      plan_hit_type ph;
      if (int'(dg_pos) < MAX_BYTES) begin
         if (int'(dg_pos) >= int'(walk_at)) begin
            rel = 17'(dg_pos) - walk_at;
            if (cand_seen) begin
               if (rel == 17'd6) cand_cls = b[2:0];
               else if (rel == 17'd7) cand_num = b;
            end else if (rel < 17'd3) begin
               hdr_bytes = {hdr_bytes[15:0], b};
            end else if (rel == 17'd3) begin
               atype = hdr_bytes[23:8];
               alen  = {1'b0, hdr_bytes[7:0], b};
               hdr_bytes = '0;
               if (atype == pr_attr_type && alen >= 17'd4) begin
                  cand_seen = 1'b1;
                  cand_stop = walk_at + 17'd4 + alen;
               end else begin
                  walk_at = walk_at + 17'd4 + ((alen + 17'd3) & ~17'd3);
               end
            end
         end
         dg_pos = dg_pos + 12'd1;
      end
      if (fin) begin
         kept = int'(dg_pos);
         code = int'(cand_cls) * secc_pkg::CODE_SCALE + int'(cand_num);
         v.hit = cand_seen && kept >= secc_pkg::HDR_BYTES && int'(cand_stop) <= kept &&
                 code == int'(pr_code);
         tot_pkt   = tot_pkt + 64'd1;
         tot_bytes = tot_bytes + 64'(kept);
         if (v.hit) tot_match = tot_match + 64'd1;
         v.match_n   = tot_match;
         v.datagrams = tot_pkt;
         v.octets    = tot_bytes;
         if (plan_hit_q.size() != 0) begin
            ph = plan_hit_q.pop_front();
            if (ph.known) v.hit = ph.val;
         end
         verdict_q.push_back(v);
         restart_walk();
      end
   endtask

   always @(posedge clock) begin : watch
      bit          moved;
      verdict_type v;
      moved = 1'b0;
      if (reset) begin
         pr_attr_type = secc_pkg::ATTR_TYPE_RESET;
         pr_code      = secc_pkg::MATCH_CODE_RESET;
         tot_match    = '0;
         tot_pkt      = '0;
         tot_bytes    = '0;
         restart_walk();
      end else begin
         if (csr_we) begin
            if (csr_index == secc_pkg::CSR_MATCH_ATTR_TYPE)
               pr_attr_type = csr_wdata[secc_pkg::ATTR_TYPE_W-1:0];
            else if (csr_index == secc_pkg::CSR_MATCH_CODE)
               pr_code = csr_wdata[secc_pkg::CODE_W-1:0];
         end
         if (req_if.valid && req_if.ready) begin
            moved = 1'b1;
            classify_byte(req_if.data_byte, req_if.last);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            moved = 1'b1;
            rsp_seen++;
            if (verdict_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected result: hit=%0d m=%0d p=%0d b=%0d", rsp_if.is_match,
                           rsp_if.match_count, rsp_if.packet_count, rsp_if.byte_count);
            end else begin
               v = verdict_q.pop_front();
               if (rsp_if.is_match !== v.hit || rsp_if.match_count !== v.match_n ||
                   rsp_if.packet_count !== v.datagrams || rsp_if.byte_count !== v.octets) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: expected hit=%0d m=%0d p=%0d b=%0d, got hit=%0d m=%0d p=%0d b=%0d",
                              v.hit, v.match_n, v.datagrams, v.octets, rsp_if.is_match,
                              rsp_if.match_count, rsp_if.packet_count, rsp_if.byte_count);
               end
            end
         end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task push_byte(input logic [7:0] b, input logic fin);
      int gap;
      gap = no_idle ? 0 : idle_len();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      req_if.last      <= fin;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task send_datagram(input logic known, input logic hit);
      plan_hit_q.push_back('{known, hit});
      no_idle = ($urandom_range(0, 3) == 0);
      foreach (dg_bytes[i]) push_byte(dg_bytes[i], i == dg_bytes.size() - 1);
   endtask

   task add_attr(input logic [15:0] atype, input logic [15:0] alen,
                 input logic [7:0] cls, input logic [7:0] num, input int cap);
      int n;
      n = (int'(alen) + 3) & ~3;
      if (n > cap) n = cap;
      dg_bytes.push_back(atype[15:8]);
      dg_bytes.push_back(atype[7:0]);
      dg_bytes.push_back(alen[15:8]);
      dg_bytes.push_back(alen[7:0]);
      for (int i = 0; i < n; i++)
         dg_bytes.push_back(i == 2 ? cls : (i == 3 ? num : 8'($urandom)));
   endtask

   task drain;
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_csr(input logic [secc_pkg::CSR_INDEX_W-1:0] idx,
                  input logic [secc_pkg::CSR_DATA_W-1:0] val);
      drain();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task gen_datagram(input logic [15:0] cfg_type, input logic [9:0] cfg_code);
      int          kind;
      int          cut;
      int          code;
      logic [15:0] ft;
      logic [15:0] fl;
      logic [15:0] cl;
      logic [7:0]  cls;
      logic [7:0]  num;
      dg_bytes.delete();
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
         repeat ($urandom_range(1, 40)) dg_bytes.push_back(8'($urandom));
      end else begin
         repeat (secc_pkg::HDR_BYTES) dg_bytes.push_back(8'($urandom));
         repeat ($urandom_range(0, 3)) begin
            ft = ($urandom_range(0, 3) == 0) ? cfg_type : 16'($urandom);
            fl = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
            if (ft == cfg_type && fl >= 16'd4) fl = 16'($urandom_range(0, 3));
            add_attr(ft, fl, 8'($urandom), 8'($urandom), 16);
         end
         if ($urandom_range(0, 99) < 85) begin
            if (cfg_code <= 10'd955 && $urandom_range(0, 99) < 75) code = int'(cfg_code);
            else code = $urandom_range(0, 955);
            cls = 8'($urandom);
            cls[2:0] = 3'(code / secc_pkg::CODE_SCALE);
            num = 8'(code % secc_pkg::CODE_SCALE);
            if ($urandom_range(0, 9) == 0) num = 8'($urandom);
            cl = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(4, 65535))
                                               : 16'($urandom_range(4, 12));
            add_attr(cfg_type, cl, cls, num, 16);
         end
         repeat ($urandom_range(0, 8)) dg_bytes.push_back(8'($urandom));
         if (kind < 27) begin
            cut = $urandom_range(1, dg_bytes.size() - 1);
            while (dg_bytes.size() > cut) void'(dg_bytes.pop_back());
         end
      end
   endtask

   initial begin : rsp_pacer
      int stall;
      rsp_if.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      rsp_if.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (!held_off && rsp_seen >= 45) begin
            held_off = 1'b1;
            stall = HOLD_OFF;
         end else begin
            stall = no_idle ? 0 : idle_len();
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("tb_top: errors");
      $finish;
   end

   initial begin : stimulus
      int          sent;
      int          ndg;
      int          r;
      logic [15:0] type_v;
      logic [15:0] code_v;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.data_byte = '0;
      req_if.last      = 1'b0;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            write_csr(plan[i].csr_idx, plan[i].csr_val);
         end else begin
            dg_bytes.delete();
            repeat (secc_pkg::HDR_BYTES) dg_bytes.push_back(8'($urandom));
            repeat (plan[i].fill_n) add_attr(plan[i].fill_type, plan[i].fill_len,
                                             8'($urandom), 8'($urandom), 4096);
            if (plan[i].has_cand) add_attr(plan[i].cand_type, plan[i].cand_len,
                                           plan[i].cls, plan[i].num, 4096);
            repeat (plan[i].extra) dg_bytes.push_back(8'($urandom));
            if (plan[i].cut != 12'd0)
               while (dg_bytes.size() > int'(plan[i].cut)) void'(dg_bytes.pop_back());
            send_datagram(plan[i].known, plan[i].hit);
         end
      end

      for (int phase = 0; phase < 6; phase++) begin
         r = $urandom_range(0, 3);
         if (r < 2) type_v = 16'h0009;
         else if (r == 2) type_v = 16'($urandom);
         else type_v = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
         r = $urandom_range(0, 99);
         if (r < 60) code_v = 16'($urandom_range(0, 955));
         else if (r < 75) code_v = 16'($urandom_range(956, 1023));
         else code_v = 16'($urandom);
         write_csr(secc_pkg::CSR_MATCH_ATTR_TYPE, type_v);
         write_csr(secc_pkg::CSR_MATCH_CODE, code_v);
         sent = 0;
         ndg  = 0;
         while (sent < 92 || ndg < 8) begin
            gen_datagram(type_v, code_v[secc_pkg::CODE_W-1:0]);
            sent += dg_bytes.size();
            ndg++;
            send_datagram(1'b0, 1'b0);
         end
      end

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0 && verdict_q.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end
endmodule

`default_nettype wire

>>> filelist.f
+incdir+hw/rtl
hw/rtl/secc_pkg.sv
hw/rtl/secc_req_if.sv
hw/rtl/secc_rsp_if.sv
hw/rtl/stun_error_code_classifier.sv
tb/tb_top.sv
